FILE: rtl/sts_pkg.sv
// Shared types, constants and helper functions of the source token scanner.
// Used by the scanner core, the token queue and the top level; depends on nothing.
package sts_pkg;

  localparam int POS_W       = 16;
  localparam int LEN_W       = 16;
  localparam int LINE_W      = 16;
  localparam int KIND_W      = 6;
  localparam int MODE_W      = 4;
  localparam int KW_CHARS    = 5;
  localparam int KW_IDX_W    = $clog2(KW_CHARS);
  localparam int KW_NUM      = 15;
  localparam int MAX_PUSH    = 3;
  localparam int CAND_NUM    = 4;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW     = $clog2(FIFO_DEPTH + 1);
  localparam int OUT_DATA_W  = 56;

  localparam logic [LEN_W-1:0]  LEN_MAX  = '1;
  localparam logic [LINE_W-1:0] LINE_MAX = '1;

  localparam logic [KIND_W-1:0] K_NEWLINE  = 6'd0;
  localparam logic [KIND_W-1:0] K_PLUS     = 6'd1;
  localparam logic [KIND_W-1:0] K_MINUS    = 6'd2;
  localparam logic [KIND_W-1:0] K_STAR     = 6'd3;
  localparam logic [KIND_W-1:0] K_COMMA    = 6'd4;
  localparam logic [KIND_W-1:0] K_LPAR     = 6'd5;
  localparam logic [KIND_W-1:0] K_RPAR     = 6'd6;
  localparam logic [KIND_W-1:0] K_SLASH    = 6'd7;
  localparam logic [KIND_W-1:0] K_EQEQ     = 6'd8;
  localparam logic [KIND_W-1:0] K_GTEQ     = 6'd9;
  localparam logic [KIND_W-1:0] K_GT       = 6'd10;
  localparam logic [KIND_W-1:0] K_LTEQ     = 6'd11;
  localparam logic [KIND_W-1:0] K_LT       = 6'd12;
  localparam logic [KIND_W-1:0] K_INT      = 6'd13;
  localparam logic [KIND_W-1:0] K_IDENT    = 6'd14;
  localparam logic [KIND_W-1:0] K_STRING   = 6'd15;
  localparam logic [KIND_W-1:0] K_KW0      = 6'd16;
  localparam logic [KIND_W-1:0] K_ERR_EQ   = 6'd31;
  localparam logic [KIND_W-1:0] K_ERR_BYTE = 6'd32;
  localparam logic [KIND_W-1:0] K_END      = 6'd33;

  localparam logic [MODE_W-1:0] M_IDLE    = 4'd0;
  localparam logic [MODE_W-1:0] M_COMMENT = 4'd1;
  localparam logic [MODE_W-1:0] M_INT     = 4'd2;
  localparam logic [MODE_W-1:0] M_IDENT   = 4'd3;
  localparam logic [MODE_W-1:0] M_STRING  = 4'd4;
  localparam logic [MODE_W-1:0] M_PSLASH  = 4'd5;
  localparam logic [MODE_W-1:0] M_PEQ     = 4'd6;
  localparam logic [MODE_W-1:0] M_PGT     = 4'd7;
  localparam logic [MODE_W-1:0] M_PLT     = 4'd8;
  localparam logic [MODE_W-1:0] M_HALT    = 4'd9;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_GT    = 8'h3E;

  localparam logic [63:0] KW_TEXT [KW_NUM] = '{
    "var", "print", "read", "for", "while", "if", "else", "elif",
    "and", "or", "not", "exit", "end", "func", "call"
  };
  localparam logic [3:0] KW_LEN [KW_NUM] = '{
    4'd3, 4'd5, 4'd4, 4'd3, 4'd5, 4'd2, 4'd4, 4'd4,
    4'd3, 4'd2, 4'd3, 4'd4, 4'd3, 4'd4, 4'd4
  };

  typedef logic [KW_CHARS-1:0][7:0] window_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  start;
    logic [LEN_W-1:0]  length;
    logic [LINE_W-1:0] line;
    logic              last;
  } token_t;

  typedef struct packed {
    logic   valid;
    token_t tok;
  } cand_t;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  // The window holds the first characters of an identifier, zero beyond its length.
  function automatic logic [KIND_W-1:0] ident_kind(window_t win, logic [LEN_W-1:0] len);
    logic [KIND_W-1:0] kind;
    logic              hit;
    logic [7:0]        exp_c;
    int                l;
    kind = K_IDENT;
    for (int k = 0; k < KW_NUM; k++) begin
      l = int'(KW_LEN[k]);
      hit = (len == LEN_W'(KW_LEN[k]));
      for (int i = 0; i < KW_CHARS; i++) begin
        exp_c = (i < l) ? KW_TEXT[k][8*(l-1-i) +: 8] : 8'h00;
        hit = hit && (win[i] == exp_c);
      end
      if (hit) begin
        kind = K_KW0 + KIND_W'(k);
      end
    end
    return kind;
  endfunction

  function automatic cand_t flush_tok(logic [MODE_W-1:0] mode, logic [POS_W-1:0] start,
                                      logic [LEN_W-1:0] len, window_t win,
                                      logic [LINE_W-1:0] line);
    cand_t c;
    c.valid      = 1'b1;
    c.tok.start  = start;
    c.tok.length = LEN_W'(1);
    c.tok.line   = line;
    c.tok.last   = 1'b0;
    c.tok.kind   = K_INT;
    case (mode)
      M_INT: begin
        c.tok.kind   = K_INT;
        c.tok.length = len;
      end
      M_IDENT: begin
        c.tok.kind   = ident_kind(win, len);
        c.tok.length = len;
      end
      M_STRING: begin
        c.tok.kind   = K_STRING;
        c.tok.length = len;
      end
      M_PSLASH: c.tok.kind = K_SLASH;
      M_PEQ:    c.tok.kind = K_ERR_EQ;
      M_PGT:    c.tok.kind = K_GT;
      M_PLT:    c.tok.kind = K_LT;
      default:  c.valid = 1'b0;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/sts_scanner.sv
// Scanner core: mode, position, pending token and line registers, and the logic
// that turns one byte into up to four ordered token candidates. Uses sts_pkg.
module sts_scanner
  import sts_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   accept,
  input  logic [7:0]             in_byte,
  input  logic                   last_byte,
  output cand_t [CAND_NUM-1:0]   cand
);

  logic [MODE_W-1:0] mode_r, mode_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [POS_W-1:0]  start_r, start_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [LINE_W-1:0] line_r, line_nxt;
  window_t           win_r, win_nxt;

  logic [MODE_W-1:0] mode_m;
  logic [POS_W-1:0]  start_m;
  logic [LEN_W-1:0]  len_m;
  logic [LINE_W-1:0] line_m;
  window_t           win_m;
  logic              do_disp;
  logic              do_ext;
  logic [POS_W-1:0]  pos_inc;
  logic [LEN_W-1:0]  len_ext;
  logic [LINE_W-1:0] line_inc;

  assign pos_inc  = pos_r + POS_W'(1);
  assign len_ext  = (len_r == LEN_MAX) ? len_r : len_r + LEN_W'(1);
  assign line_inc = (line_r == LINE_MAX) ? line_r : line_r + LINE_W'(1);

  always_comb begin
    mode_m  = mode_r;
    start_m = start_r;
    len_m   = len_r;
    line_m  = line_r;
    win_m   = win_r;
    do_disp = 1'b0;
    do_ext  = 1'b0;
    cand    = '0;

    case (mode_r)
      M_HALT: begin
      end
      M_COMMENT: begin
        if (in_byte == CH_LF) begin
          mode_m = M_IDLE;
        end
      end
      M_INT: begin
        if (is_digit(in_byte)) begin
          do_ext = 1'b1;
        end else begin
          cand[0] = flush_tok(mode_r, start_r, len_r, win_r, line_r);
          do_disp = 1'b1;
        end
      end
      M_IDENT: begin
        if (is_digit(in_byte) || is_alpha(in_byte)) begin
          do_ext = 1'b1;
        end else begin
          cand[0] = flush_tok(mode_r, start_r, len_r, win_r, line_r);
          do_disp = 1'b1;
        end
      end
      M_STRING: begin
        if (in_byte != CH_QUOTE) begin
          do_ext = 1'b1;
        end else begin
          cand[0] = flush_tok(mode_r, start_r, len_r, win_r, line_r);
          mode_m  = M_IDLE;
        end
      end
      M_PSLASH: begin
        if (in_byte == CH_SLASH) begin
          mode_m = M_COMMENT;
        end else begin
          cand[0] = flush_tok(mode_r, start_r, len_r, win_r, line_r);
          do_disp = 1'b1;
        end
      end
      M_PEQ, M_PGT, M_PLT: begin
        if (in_byte == CH_EQ) begin
          cand[0].valid      = 1'b1;
          cand[0].tok.kind   = (mode_r == M_PEQ) ? K_EQEQ :
                               ((mode_r == M_PGT) ? K_GTEQ : K_LTEQ);
          cand[0].tok.start  = start_r;
          cand[0].tok.length = LEN_W'(2);
          cand[0].tok.line   = line_r;
          cand[0].tok.last   = 1'b0;
          mode_m = M_IDLE;
        end else begin
          cand[0] = flush_tok(mode_r, start_r, len_r, win_r, line_r);
          do_disp = 1'b1;
        end
      end
      default: do_disp = 1'b1;
    endcase

    if (do_ext) begin
      if ((mode_r == M_IDENT) && (len_r < LEN_W'(KW_CHARS))) begin
        win_m[len_r[KW_IDX_W-1:0]] = in_byte;
      end
      len_m = len_ext;
    end

    if (do_disp) begin
      mode_m             = M_IDLE;
      cand[1].tok.start  = pos_r;
      cand[1].tok.length = LEN_W'(1);
      cand[1].tok.line   = line_r;
      cand[1].tok.last   = 1'b0;
      cand[1].tok.kind   = K_NEWLINE;
      case (in_byte)
        CH_SP, CH_TAB, CH_CR: begin
        end
        CH_LF: begin
          cand[1].valid = 1'b1;
          line_m        = line_inc;
        end
        CH_PLUS: begin
          cand[1].valid    = 1'b1;
          cand[1].tok.kind = K_PLUS;
        end
        CH_MINUS: begin
          cand[1].valid    = 1'b1;
          cand[1].tok.kind = K_MINUS;
        end
        CH_STAR: begin
          cand[1].valid    = 1'b1;
          cand[1].tok.kind = K_STAR;
        end
        CH_COMMA: begin
          cand[1].valid    = 1'b1;
          cand[1].tok.kind = K_COMMA;
        end
        CH_LPAR: begin
          cand[1].valid    = 1'b1;
          cand[1].tok.kind = K_LPAR;
        end
        CH_RPAR: begin
          cand[1].valid    = 1'b1;
          cand[1].tok.kind = K_RPAR;
        end
        CH_SLASH, CH_EQ, CH_GT, CH_LT: begin
          mode_m  = (in_byte == CH_SLASH) ? M_PSLASH :
                    ((in_byte == CH_EQ) ? M_PEQ :
                    ((in_byte == CH_GT) ? M_PGT : M_PLT));
          start_m = pos_r;
          len_m   = LEN_W'(1);
        end
        CH_QUOTE: begin
          mode_m  = M_STRING;
          start_m = pos_inc;
          len_m   = '0;
        end
        default: begin
          if (is_digit(in_byte)) begin
            mode_m  = M_INT;
            start_m = pos_r;
            len_m   = LEN_W'(1);
          end else if (is_alpha(in_byte)) begin
            mode_m   = M_IDENT;
            start_m  = pos_r;
            len_m    = LEN_W'(1);
            win_m    = '0;
            win_m[0] = in_byte;
          end else begin
            cand[1].valid    = 1'b1;
            cand[1].tok.kind = K_ERR_BYTE;
            mode_m           = M_HALT;
          end
        end
      endcase
    end

    if (last_byte) begin
      cand[2]            = flush_tok(mode_m, start_m, len_m, win_m, line_m);
      cand[3].valid      = 1'b1;
      cand[3].tok.kind   = K_END;
      cand[3].tok.start  = pos_inc;
      cand[3].tok.length = '0;
      cand[3].tok.line   = line_m;
      cand[3].tok.last   = 1'b1;
    end
  end

  always_comb begin
    mode_nxt  = mode_r;
    pos_nxt   = pos_r;
    start_nxt = start_r;
    len_nxt   = len_r;
    line_nxt  = line_r;
    win_nxt   = win_r;
    if (accept) begin
      if (last_byte) begin
        mode_nxt  = M_IDLE;
        pos_nxt   = '0;
        start_nxt = '0;
        len_nxt   = '0;
        line_nxt  = LINE_W'(1);
        win_nxt   = '0;
      end else begin
        mode_nxt  = mode_m;
        pos_nxt   = pos_inc;
        start_nxt = start_m;
        len_nxt   = len_m;
        line_nxt  = line_m;
        win_nxt   = win_m;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_IDLE;
      pos_r   <= '0;
      start_r <= '0;
      len_r   <= '0;
      line_r  <= LINE_W'(1);
      win_r   <= '0;
    end else begin
      mode_r  <= mode_nxt;
      pos_r   <= pos_nxt;
      start_r <= start_nxt;
      len_r   <= len_nxt;
      line_r  <= line_nxt;
      win_r   <= win_nxt;
    end
  end

endmodule

FILE: rtl/sts_token_fifo.sv
// Four-entry token queue: takes up to four ordered candidates per beat and hands
// out one token per beat. Uses sts_pkg.
module sts_token_fifo
  import sts_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  cand_t [CAND_NUM-1:0] cand,
  output logic                 room,
  output logic                 head_valid,
  input  logic                 head_ready,
  output token_t               head
);

  token_t               mem_r [FIFO_DEPTH];
  token_t               mem_nxt [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CW-1:0]   count_r, count_nxt;
  logic [FIFO_AW-1:0]   off;
  logic [FIFO_CW-1:0]   n_push;
  logic                 pop;

  assign room       = (count_r <= FIFO_CW'(FIFO_DEPTH - MAX_PUSH));
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];
  assign pop        = head_valid && head_ready;

  always_comb begin
    mem_nxt = mem_r;
    off     = '0;
    n_push  = '0;
    for (int i = 0; i < CAND_NUM; i++) begin
      if (push && cand[i].valid) begin
        mem_nxt[wr_ptr_r + off] = cand[i].tok;
        off    = off + FIFO_AW'(1);
        n_push = n_push + FIFO_CW'(1);
      end
    end
    wr_ptr_nxt = wr_ptr_r + n_push[FIFO_AW-1:0];
    rd_ptr_nxt = pop ? rd_ptr_r + FIFO_AW'(1) : rd_ptr_r;
    count_nxt  = count_r + n_push - (pop ? FIFO_CW'(1) : FIFO_CW'(0));
  end

  always_ff @(posedge clk) begin
    mem_r <= mem_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

FILE: rtl/source_token_scanner.sv
// Top level of the source token scanner: scanner core feeding the token queue.
// Depends on sts_pkg, sts_scanner and sts_token_fifo.
//
// The block takes one source byte per beat and returns tokens (kind, start offset,
// length, line number) one per beat. A byte gives zero to three tokens. Input is
// taken every cycle while the four-entry token queue has at least three free
// entries, so the sustained rate is one byte per cycle whenever the output side
// takes one token per cycle; a byte that gives more tokens than are drained holds
// the input until the queue again has three free entries. The byte marked by
// in_tlast ends the stream and is followed by an end token flagged with out_tlast,
// after which the next byte starts a new stream.
module source_token_scanner
  import sts_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] in_byte
  input  logic                  in_tlast,   // last_byte
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [5:0] token_kind, [21:6] token_start,
                                            // [37:22] token_length, [53:38] line_number
  output logic                  out_tlast   // last_result
);

  cand_t [CAND_NUM-1:0] cand;
  token_t               head;
  logic                 accept;

  assign accept = in_tvalid && in_tready;

  sts_scanner u_scanner (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_byte   (in_tdata),
    .last_byte (in_tlast),
    .cand      (cand)
  );

  sts_token_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (accept),
    .cand       (cand),
    .room       (in_tready),
    .head_valid (out_tvalid),
    .head_ready (out_tready),
    .head       (head)
  );

  assign out_tdata = {2'b00, head.line, head.length, head.start, head.kind};
  assign out_tlast = head.last;

  a_end_token_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> (out_tdata[5:0] == K_END) && (out_tdata[37:22] == '0))
    else $error("end token with wrong kind or length");

  a_stall_means_backlog: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with an empty token queue");

  a_last_gives_token: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> out_tvalid)
    else $error("no token after the final byte");

  a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[53:38] != '0))
    else $error("token with line number zero");

endmodule

FILE: test/token_stream_checker.sv
`timescale 1ns / 1ps
// Watches both streams of the source token scanner, predicts the tokens of
// every accepted source byte and compares them beat by beat. Depends on sts_pkg.
module token_stream_checker
  import sts_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] in_byte
  input  logic                  in_tlast,   // last_byte
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,  // [5:0] kind, [21:6] start, [37:22] length,
                                            // [53:38] line
  input  logic                  out_tlast,  // last_result
  output int                    fail_count,
  output int                    pending
);

  localparam logic [39:0] KEYWORDS [KW_NUM] = '{
    "var", "print", "read", "for", "while", "if", "else", "elif",
    "and", "or", "not", "exit", "end", "func", "call"
  };

  token_t            due_tokens [$];
  logic [MODE_W-1:0] mode;
  logic [15:0]       pos_q;
  logic [15:0]       pstart;
  logic [15:0]       plen;
  logic [15:0]       line_q;
  logic [7:0]        win [KW_CHARS];
  int                nres;
  int                errs = 0;

  task automatic flag_mismatch(string msg);
    if (errs < 40) begin
      $display("mismatch at %0t: %s", $realtime, msg);
    end
    errs++;
  endtask

  function automatic logic num_char(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic letter(logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic [KIND_W-1:0] word_kind();
    logic [39:0] w;
    int          n;
    logic        hit;
    for (int k = 0; k < KW_NUM; k++) begin
      w = KEYWORDS[k];
      n = 0;
      for (int i = 0; i < 5; i++) begin
        if (w[8*i +: 8] != 8'h00) n++;
      end
      hit = (plen == 16'(n));
      for (int i = 0; i < n; i++) begin
        if (win[i] != w[8*(n-1-i) +: 8]) hit = 1'b0;
      end
      if (hit) return K_KW0 + KIND_W'(k);
    end
    return K_IDENT;
  endfunction

  task automatic clear_scan();
    mode   = M_IDLE;
    pos_q  = '0;
    pstart = '0;
    plen   = '0;
    line_q = 16'd1;
    for (int i = 0; i < KW_CHARS; i++) win[i] = 8'h00;
  endtask

  task automatic push_tok(logic [KIND_W-1:0] kind, logic [15:0] start, logic [15:0] len,
                          logic fin);
    token_t t;
    if (nres < MAX_PUSH) begin
      t.kind   = kind;
      t.start  = start;
      t.length = len;
      t.line   = line_q;
      t.last   = fin;
      due_tokens.push_back(t);
      nres++;
    end
  endtask

  task automatic open_pending(logic [MODE_W-1:0] m, logic [15:0] start, logic [15:0] len);
    mode   = m;
    pstart = start;
    plen   = len;
  endtask

  task automatic grow_pending(logic [7:0] c);
    if (mode == M_IDENT && plen < KW_CHARS) win[plen[2:0]] = c;
    if (plen != 16'hFFFF) plen++;
  endtask

  task automatic flush_pending();
    case (mode)
      M_INT:    push_tok(K_INT, pstart, plen, 1'b0);
      M_IDENT:  push_tok(word_kind(), pstart, plen, 1'b0);
      M_STRING: push_tok(K_STRING, pstart, plen, 1'b0);
      M_PSLASH: push_tok(K_SLASH, pstart, 16'd1, 1'b0);
      M_PEQ:    push_tok(K_ERR_EQ, pstart, 16'd1, 1'b0);
      M_PGT:    push_tok(K_GT, pstart, 16'd1, 1'b0);
      M_PLT:    push_tok(K_LT, pstart, 16'd1, 1'b0);
      default: ;
    endcase
  endtask

  task automatic fresh_byte(logic [7:0] c, logic [15:0] p);
    mode = M_IDLE;
    case (c)
      CH_SP, CH_TAB, CH_CR: ;
      CH_LF: begin
        push_tok(K_NEWLINE, p, 16'd1, 1'b0);
        if (line_q != 16'hFFFF) line_q++;
      end
      CH_PLUS:  push_tok(K_PLUS, p, 16'd1, 1'b0);
      CH_MINUS: push_tok(K_MINUS, p, 16'd1, 1'b0);
      CH_STAR:  push_tok(K_STAR, p, 16'd1, 1'b0);
      CH_COMMA: push_tok(K_COMMA, p, 16'd1, 1'b0);
      CH_LPAR:  push_tok(K_LPAR, p, 16'd1, 1'b0);
      CH_RPAR:  push_tok(K_RPAR, p, 16'd1, 1'b0);
      CH_SLASH: open_pending(M_PSLASH, p, 16'd1);
      CH_EQ:    open_pending(M_PEQ, p, 16'd1);
      CH_GT:    open_pending(M_PGT, p, 16'd1);
      CH_LT:    open_pending(M_PLT, p, 16'd1);
      CH_QUOTE: open_pending(M_STRING, p + 16'd1, 16'd0);
      default: begin
        if (num_char(c)) begin
          open_pending(M_INT, p, 16'd1);
        end else if (letter(c)) begin
          open_pending(M_IDENT, p, 16'd1);
          for (int i = 0; i < KW_CHARS; i++) win[i] = 8'h00;
          win[0] = c;
        end else begin
          push_tok(K_ERR_BYTE, p, 16'd1, 1'b0);
          mode = M_HALT;
        end
      end
    endcase
  endtask

  task automatic lex_byte(logic [7:0] c, logic fin);
    logic [15:0] p;
    p    = pos_q;
    nres = 0;
    case (mode)
      M_HALT: ;
      M_COMMENT: begin
        if (c == CH_LF) mode = M_IDLE;
      end
      M_INT: begin
        if (num_char(c)) begin
          grow_pending(c);
        end else begin
          flush_pending();
          fresh_byte(c, p);
        end
      end
      M_IDENT: begin
        if (num_char(c) || letter(c)) begin
          grow_pending(c);
        end else begin
          flush_pending();
          fresh_byte(c, p);
        end
      end
      M_STRING: begin
        if (c != CH_QUOTE) begin
          grow_pending(c);
        end else begin
          flush_pending();
          mode = M_IDLE;
        end
      end
      M_PSLASH: begin
        if (c == CH_SLASH) begin
          mode = M_COMMENT;
        end else begin
          flush_pending();
          fresh_byte(c, p);
        end
      end
      M_PEQ, M_PGT, M_PLT: begin
        if (c == CH_EQ) begin
          push_tok(mode == M_PEQ ? K_EQEQ : (mode == M_PGT ? K_GTEQ : K_LTEQ),
                   pstart, 16'd2, 1'b0);
          mode = M_IDLE;
        end else begin
          flush_pending();
          fresh_byte(c, p);
        end
      end
      default: fresh_byte(c, p);
    endcase
    pos_q = p + 16'd1;
    if (fin) begin
      flush_pending();
      push_tok(K_END, pos_q, 16'd0, 1'b1);
      clear_scan();
    end
  endtask

  always @(posedge clk) begin
    token_t got;
    token_t want;
    if (!rst_n) begin
      clear_scan();
      due_tokens.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got.kind   = out_tdata[5:0];
        got.start  = out_tdata[21:6];
        got.length = out_tdata[37:22];
        got.line   = out_tdata[53:38];
        got.last   = out_tlast;
        if (due_tokens.size() == 0) begin
          flag_mismatch($sformatf("token beat with none expected, kind %0d", got.kind));
        end else begin
          want = due_tokens.pop_front();
          if (got.kind != want.kind)
            flag_mismatch($sformatf("kind %0d, expected %0d", got.kind, want.kind));
          if (got.start != want.start)
            flag_mismatch($sformatf("start %0d, expected %0d", got.start, want.start));
          if (got.length != want.length)
            flag_mismatch($sformatf("length %0d, expected %0d", got.length, want.length));
          if (got.line != want.line)
            flag_mismatch($sformatf("line %0d, expected %0d", got.line, want.line));
          if (got.last != want.last)
            flag_mismatch($sformatf("last %0b, expected %0b", got.last, want.last));
        end
      end
      if (in_tvalid && in_tready) lex_byte(in_tdata, in_tlast);
    end
    fail_count <= errs;
    pending    <= due_tokens.size();
  end

endmodule

FILE: test/source_token_scanner_tb.sv
`timescale 1ns / 1ps
// Top of the source token scanner test: clock, reset, byte stimulus and output stalls.
// Depends on sts_pkg, source_token_scanner and token_stream_checker.
module source_token_scanner_tb;
  import sts_pkg::*;

  localparam logic [39:0] WORDS [KW_NUM] = '{
    "var", "print", "read", "for", "while", "if", "else", "elif",
    "and", "or", "not", "exit", "end", "func", "call"
  };

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [7:0]            in_tdata;   // [7:0] in_byte
  logic                  in_tlast;   // last_byte
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;  // [5:0] kind, [21:6] start, [37:22] length,
                                     // [53:38] line
  logic                  out_tlast;  // last_result
  int                    fail_count;
  int                    pending;
  bit                    idle_on = 1'b1;
  int                    stall_left = 0;
  logic [7:0]            src [$];

  source_token_scanner dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  token_stream_checker u_tok_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic send_byte(logic [7:0] c, logic fin);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= fin;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_text(string s, logic fin);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], fin && (i == s.len() - 1));
  endtask

  function automatic logic [7:0] rand_letter();
    return ($urandom_range(0, 1) == 0) ? 8'(8'h41 + $urandom_range(0, 25))
                                       : 8'(8'h61 + $urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] rand_alnum();
    return ($urandom_range(0, 3) == 0) ? 8'(8'h30 + $urandom_range(0, 9)) : rand_letter();
  endfunction

  function automatic logic [7:0] rand_text_char();
    logic [7:0] c;
    c = 8'($urandom_range(8'h20, 8'h7E));
    return (c == CH_QUOTE) ? 8'h71 : c;
  endfunction

  task automatic add_piece(output bit stop);
    int          r;
    logic [39:0] w;
    stop = 1'b0;
    r = $urandom_range(0, 99);
    if (r < 20) begin
      if ($urandom_range(0, 2) == 0) begin
        w = WORDS[$urandom_range(0, KW_NUM - 1)];
        for (int i = 4; i >= 0; i--) begin
          if (w[8*i +: 8] != 8'h00) src.push_back(w[8*i +: 8]);
        end
        if ($urandom_range(0, 3) == 0) src.push_back(rand_alnum());
      end else begin
        src.push_back(rand_letter());
        repeat ($urandom_range(0, 6)) src.push_back(rand_alnum());
      end
    end else if (r < 32) begin
      repeat ($urandom_range(1, 5)) src.push_back(8'(8'h30 + $urandom_range(0, 9)));
    end else if (r < 42) begin
      src.push_back(CH_QUOTE);
      repeat ($urandom_range(0, 6)) begin
        src.push_back(($urandom_range(0, 5) == 0) ? CH_LF : rand_text_char());
      end
      if ($urandom_range(0, 9) != 0) src.push_back(CH_QUOTE);
    end else if (r < 62) begin
      case ($urandom_range(0, 11))
        0: src.push_back(CH_PLUS);
        1: src.push_back(CH_MINUS);
        2: src.push_back(CH_STAR);
        3: src.push_back(CH_COMMA);
        4: src.push_back(CH_LPAR);
        5: src.push_back(CH_RPAR);
        6: src.push_back(CH_SLASH);
        7: begin
          src.push_back(CH_EQ);
          src.push_back(CH_EQ);
        end
        8: begin
          src.push_back(CH_GT);
          src.push_back(CH_EQ);
        end
        9: begin
          src.push_back(CH_LT);
          src.push_back(CH_EQ);
        end
        10: src.push_back(CH_GT);
        default: src.push_back(CH_LT);
      endcase
    end else if (r < 76) begin
      case ($urandom_range(0, 2))
        0: src.push_back(CH_SP);
        1: src.push_back(CH_TAB);
        default: src.push_back(CH_CR);
      endcase
    end else if (r < 84) begin
      src.push_back(CH_LF);
    end else if (r < 91) begin
      src.push_back(CH_SLASH);
      src.push_back(CH_SLASH);
      repeat ($urandom_range(0, 5)) src.push_back(rand_text_char());
      if ($urandom_range(0, 6) != 0) src.push_back(CH_LF);
    end else if (r < 96) begin
      src.push_back(CH_EQ);
      src.push_back(($urandom_range(0, 1) == 0) ? rand_letter() : CH_SP);
    end else begin
      src.push_back(8'($urandom_range(0, 255)));
      stop = 1'b1;
    end
  endtask

  initial begin
    int sent;
    int pieces;
    bit stop;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = 8'h00;
    in_tlast  = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    send_text("x==y=1", 1'b1);
    send_text(">=<\"a\nb", 1'b1);
    send_text("//z\n=", 1'b1);
    send_text("(/", 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte("a", 1'b0);
    send_byte(8'hFF, 1'b1);
    send_text("//", 1'b1);

    sent = 0;
    while (sent < 180) begin
      src.delete();
      pieces = $urandom_range(1, 10);
      stop = 1'b0;
      for (int i = 0; i < pieces && !stop; i++) add_piece(stop);
      if (stop) repeat ($urandom_range(0, 2)) src.push_back(8'($urandom_range(0, 255)));
      if (sent >= 120) idle_on = 1'b0;
      foreach (src[i]) send_byte(src[i], i == src.size() - 1);
      sent += src.size();
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: source_token_scanner.f
rtl/sts_pkg.sv
rtl/sts_scanner.sv
rtl/sts_token_fifo.sv
rtl/source_token_scanner.sv
test/token_stream_checker.sv
test/source_token_scanner_tb.sv
